>>> hw/rtl/gcvc_pkg.sv
// Shared widths, register indexes, status codes and reset values of the grid cell visit counter.
package gcvc_pkg;

  // Field widths.
  localparam int LAT_W   = 28;
  localparam int LNG_W   = 29;
  localparam int COLS_W  = 24;
  localparam int ID_W    = 25;
  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 10;
  localparam int STAT_W  = 3;
  localparam int USED_W  = 11;
  localparam int CFGI_W  = 3;
  localparam int CFGD_W  = 29;

  // The shared divider works on offset magnitudes and cell sizes.
  localparam int DIVN_W  = 30;
  localparam int DIVD_W  = 29;
  localparam int DIVC_W  = 5;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_ORIGIN_LAT = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_ORIGIN_LNG = 3'd1;
  localparam logic [CFGI_W-1:0] CFG_CELL_LAT   = 3'd2;
  localparam logic [CFGI_W-1:0] CFG_CELL_LNG   = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_COLUMNS    = 3'd4;
  localparam logic [CFGI_W-1:0] CFG_TOTAL      = 3'd5;

  // Register reset values.
  localparam logic [LAT_W-1:0]  RST_ORIGIN_LAT = 28'd39410000;
  localparam logic [LNG_W-1:0]  RST_ORIGIN_LNG = 29'd115360000;
  localparam logic [LAT_W-1:0]  RST_CELL_LAT   = 28'd10000;
  localparam logic [LNG_W-1:0]  RST_CELL_LNG   = 29'd10000;
  localparam logic [COLS_W-1:0] RST_COLUMNS    = 24'd216;
  localparam logic [COLS_W-1:0] RST_TOTAL      = 24'd36504;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_HIT   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NEW   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_OUT   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

  // Request to the shared divider.
  typedef struct packed {
    logic              go;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

endpackage

>>> hw/rtl/gcvc_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module gcvc_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gcvc_pkg::div_req_t       req,
  output logic                     done,
  output logic [gcvc_pkg::DIVN_W-1:0] quotient
);
  import gcvc_pkg::*;

  logic [DIVD_W-1:0] div_r;
  logic [DIVD_W:0]   rem_r, rem_nxt;
  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [DIVC_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W+1:0] trial;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    shifted  = {rem_r[DIVD_W-1:0], quo_r[DIVN_W-1]};
    trial    = {1'b0, shifted} - {2'b00, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.go) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      cnt_nxt = DIVC_W'(DIVN_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[DIVD_W+1]) begin
        rem_nxt = trial[DIVD_W:0];
        quo_nxt = {quo_r[DIVN_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DIVN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (req.go) begin
      div_r <= req.divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/grid_cell_visit_counter.sv
// Top level of the grid cell visit counter: sequencer, id and count tables, result register.
// A record beat keeps busy high through division, multiplication and range check (two 30-step
// divisions, each with its start and finish, a multiply and an add). After that the id table is
// scanned at one slot per cycle, limited by its single read port. A hit ends the scan at its slot;
// a new id or a drop ends it after the used entries, or at once when the table is empty. An
// out-of-map id ends the beat without a scan. An out-of-map point from a zero cell size does not
// raise busy at all. A read beat keeps busy high through its issue and done states. Apart from
// the zero cell size case, each result shows in the cycle that busy falls, for one cycle under
// out_valid, and cannot be held off by the receiver. Configuration writes are always taken
// (cfg_ready is tied high) and must only be made while the block is idle.
module grid_cell_visit_counter #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic signed [gcvc_pkg::LAT_W-1:0] in_point_lat,
  input  logic signed [gcvc_pkg::LNG_W-1:0] in_point_lng,
  input  logic [gcvc_pkg::SLOT_W-1:0]       in_entry_index,
  output logic                              out_valid,
  output logic [gcvc_pkg::ID_W-1:0]         out_cell_id,
  output logic [gcvc_pkg::CNT_W-1:0]        out_visit_count,
  output logic [gcvc_pkg::SLOT_W-1:0]       out_slot,
  output logic [gcvc_pkg::STAT_W-1:0]       out_status,
  output logic [gcvc_pkg::USED_W-1:0]       out_entries_used,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gcvc_pkg::CFGI_W-1:0]       cfg_index,
  input  logic [gcvc_pkg::CFGD_W-1:0]       cfg_data
);
  import gcvc_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LAT_GO   = 4'd1;
  localparam logic [3:0] S_LAT_WAIT = 4'd2;
  localparam logic [3:0] S_LNG_GO   = 4'd3;
  localparam logic [3:0] S_LNG_WAIT = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_ADD      = 4'd6;
  localparam logic [3:0] S_SEARCH   = 4'd7;
  localparam logic [3:0] S_RD_ISSUE = 4'd8;
  localparam logic [3:0] S_RD_DONE  = 4'd9;

  // Configuration registers.
  logic [LAT_W-1:0]  origin_lat_r;
  logic [LNG_W-1:0]  origin_lng_r;
  logic [LAT_W-1:0]  cell_lat_r;
  logic [LNG_W-1:0]  cell_lng_r;
  logic [COLS_W-1:0] columns_r;
  logic [COLS_W-1:0] total_r;

  // Sequencer and working registers.
  logic [3:0]          state_r, state_nxt;
  logic [UW-1:0]       used_r, used_nxt;
  logic [UW-1:0]       scan_r, scan_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]       cmp_idx_r;
  logic [DIVN_W-1:0]   lat_mag_r, lng_mag_r;
  logic                lat_neg_r, lng_neg_r;
  logic signed [30:0]  row_r, col_r;
  logic signed [55:0]  prod_r;
  logic [ID_W-1:0]     id_r;
  logic [SLOT_W-1:0]   rd_idx_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;

  // Tables.
  logic [ID_W-1:0]     id_mem  [TABLE_DEPTH];
  logic [CNT_W-1:0]    cnt_mem [TABLE_DEPTH];
  logic [ID_W-1:0]     q_id_r;
  logic [CNT_W-1:0]    q_cnt_r;
  logic [IW-1:0]       raddr, waddr;
  logic                we_id, we_cnt;
  logic [CNT_W-1:0]    wcnt;

  // Divider hookup.
  div_req_t            div_req;
  logic                div_done;
  logic [DIVN_W-1:0]   div_quo;

  // Combinational helpers.
  logic signed [28:0]  dlat;
  logic signed [29:0]  dlng;
  logic [DIVN_W-1:0]   dlat_ext;
  logic signed [30:0]  quo_signed;
  logic signed [56:0]  id_sum;
  logic [31:0]         rd_idx32, cmp_idx32, used32;
  logic                id_match;
  logic [CNT_W-1:0]    cnt_inc;

  gcvc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_lat_r <= RST_ORIGIN_LAT;
      origin_lng_r <= RST_ORIGIN_LNG;
      cell_lat_r   <= RST_CELL_LAT;
      cell_lng_r   <= RST_CELL_LNG;
      columns_r    <= RST_COLUMNS;
      total_r      <= RST_TOTAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_LAT: origin_lat_r <= cfg_data[LAT_W-1:0];
        CFG_ORIGIN_LNG: origin_lng_r <= cfg_data[LNG_W-1:0];
        CFG_CELL_LAT:   cell_lat_r   <= cfg_data[LAT_W-1:0];
        CFG_CELL_LNG:   cell_lng_r   <= cfg_data[LNG_W-1:0];
        CFG_COLUMNS:    columns_r    <= cfg_data[COLS_W-1:0];
        CFG_TOTAL:      total_r      <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Offsets from the map origin and the signed quotient.
  always_comb begin
    dlat       = {in_point_lat[LAT_W-1], in_point_lat} - {origin_lat_r[LAT_W-1], origin_lat_r};
    dlng       = {in_point_lng[LNG_W-1], in_point_lng} - {origin_lng_r[LNG_W-1], origin_lng_r};
    dlat_ext   = {dlat[28], dlat};
    quo_signed = (state_r == S_LAT_WAIT ? lat_neg_r : lng_neg_r)
                 ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    id_sum     = {prod_r[55], prod_r} + {{26{col_r[30]}}, col_r} + 57'sd1;
    rd_idx32   = 32'(rd_idx_r);
    cmp_idx32  = 32'(cmp_idx_r);
    used32     = 32'(used_r);
    id_match   = cmp_vld_r && (q_id_r == id_r);
    cnt_inc    = (q_cnt_r == '1) ? q_cnt_r : q_cnt_r + 1'b1;
  end

  // Divider request: latitude first, then longitude.
  always_comb begin
    div_req.go       = (state_r == S_LAT_GO) || (state_r == S_LNG_GO);
    div_req.dividend = (state_r == S_LAT_GO) ? lat_mag_r : lng_mag_r;
    div_req.divisor  = (state_r == S_LAT_GO) ? {1'b0, cell_lat_r} : cell_lng_r;
  end

  // Table read address: the scan counter while searching, the requested slot otherwise.
  assign raddr = (state_r == S_SEARCH) ? scan_r[IW-1:0] : rd_idx32[IW-1:0];

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    res_id_nxt    = res_id_r;
    res_cnt_nxt   = res_cnt_r;
    res_slot_nxt  = res_slot_r;
    res_stat_nxt  = res_stat_r;
    we_id         = 1'b0;
    we_cnt        = 1'b0;
    waddr         = cmp_idx_r;
    wcnt          = cnt_inc;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_mode) begin
            state_nxt = S_RD_ISSUE;
          end else if (cell_lat_r == '0 || cell_lng_r == '0) begin
            out_valid_nxt = 1'b1;
            res_id_nxt    = '0;
            res_cnt_nxt   = '0;
            res_slot_nxt  = '0;
            res_stat_nxt  = STAT_OUT;
          end else begin
            state_nxt = S_LAT_GO;
          end
        end
      end
      S_LAT_GO:   state_nxt = S_LAT_WAIT;
      S_LAT_WAIT: if (div_done) state_nxt = S_LNG_GO;
      S_LNG_GO:   state_nxt = S_LNG_WAIT;
      S_LNG_WAIT: if (div_done) state_nxt = S_MUL;
      S_MUL:      state_nxt = S_ADD;
      S_ADD: begin
        if (id_sum[56] || id_sum > $signed({33'd0, total_r})) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_id_nxt    = '0;
          res_cnt_nxt   = '0;
          res_slot_nxt  = '0;
          res_stat_nxt  = STAT_OUT;
        end else begin
          state_nxt = S_SEARCH;
          scan_nxt  = '0;
        end
      end
      S_SEARCH: begin
        // One slot read per cycle; the compare uses the registered read data of the slot read just before.
        if (id_match) begin
          state_nxt     = S_IDLE;
          we_cnt        = 1'b1;
          out_valid_nxt = 1'b1;
          res_id_nxt    = id_r;
          res_cnt_nxt   = cnt_inc;
          res_slot_nxt  = cmp_idx32[SLOT_W-1:0];
          res_stat_nxt  = STAT_HIT;
        end else if (!cmp_vld_r && scan_r >= used_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_id_nxt    = id_r;
          if (used32 < 32'(TABLE_DEPTH)) begin
            waddr        = used_r[IW-1:0];
            wcnt         = CNT_W'(1);
            we_id        = 1'b1;
            we_cnt       = 1'b1;
            used_nxt     = used_r + 1'b1;
            res_cnt_nxt  = CNT_W'(1);
            res_slot_nxt = used32[SLOT_W-1:0];
            res_stat_nxt = STAT_NEW;
          end else begin
            res_cnt_nxt  = '0;
            res_slot_nxt = '0;
            res_stat_nxt = STAT_FULL;
          end
        end else begin
          cmp_vld_nxt = scan_r < used_r;
          if (scan_r < used_r) scan_nxt = scan_r + 1'b1;
        end
      end
      S_RD_ISSUE: state_nxt = S_RD_DONE;
      S_RD_DONE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        res_slot_nxt  = rd_idx_r;
        if (rd_idx32 < used32) begin
          res_id_nxt   = q_id_r;
          res_cnt_nxt  = q_cnt_r;
          res_stat_nxt = STAT_HIT;
        end else begin
          res_id_nxt   = '0;
          res_cnt_nxt  = '0;
          res_stat_nxt = STAT_EMPTY;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    cmp_idx_r  <= scan_r[IW-1:0];
    res_id_r   <= res_id_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_slot_r <= res_slot_nxt;
    res_stat_r <= res_stat_nxt;
    if (state_r == S_IDLE && start) begin
      lat_neg_r <= dlat[28];
      lat_mag_r <= dlat[28] ? (~dlat_ext + 1'b1) : dlat_ext;
      lng_neg_r <= dlng[29];
      lng_mag_r <= dlng[29] ? (~dlng + 1'b1) : dlng;
      rd_idx_r  <= in_entry_index;
    end
    if (state_r == S_LAT_WAIT && div_done) row_r <= quo_signed;
    if (state_r == S_LNG_WAIT && div_done) col_r <= quo_signed;
    if (state_r == S_MUL) prod_r <= row_r * $signed({1'b0, columns_r});
    if (state_r == S_ADD) id_r <= id_sum[ID_W-1:0];
  end

  // Tables: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we_id)  id_mem[waddr]  <= id_r;
    if (we_cnt) cnt_mem[waddr] <= wcnt;
    q_id_r  <= id_mem[raddr];
    q_cnt_r <= cnt_mem[raddr];
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_cell_id      = res_id_r;
  assign out_visit_count  = res_cnt_r;
  assign out_slot         = res_slot_r;
  assign out_status       = res_stat_r;
  assign out_entries_used = used32[USED_W-1:0];

endmodule
